@@ rtl/trma_pkg.sv @@
package trma_pkg;

   // Widths of the channel fields.
   localparam int OP_W     = 2;
   localparam int FIELD_W  = 64;
   localparam int KIND_W   = 3;
   localparam int ALIGN_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_FREE   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd3;

   // Kind that marks an untyped range.
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;

endpackage

@@ rtl/trma_if.sv @@
interface trma_req_if;
   import trma_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FIELD_W-1:0] range_start;
   logic [FIELD_W-1:0] range_length;
   logic [KIND_W-1:0]  range_kind;
   logic [ALIGN_W-1:0] alignment;

   modport source (output valid, operation, range_start, range_length, range_kind, alignment,
                   input ready);
   modport sink   (input valid, operation, range_start, range_length, range_kind, alignment,
                   output ready);
endinterface

interface trma_rsp_if;
   import trma_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  granted_start;

   modport source (output valid, status, granted_start, input ready);
   modport sink   (input valid, status, granted_start, output ready);
endinterface

@@ rtl/trma_entry_mem.sv @@
module trma_entry_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_idx];
      end
   end

endmodule

@@ rtl/trma_align_div.sv @@
module trma_align_div #(
   parameter int AB = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AB-1:0] dividend,
   input  logic [31:0]   divisor,
   output logic          done,
   output logic [31:0]   remainder
);
   import trma_pkg::*;

   localparam int CW = $clog2(AB + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AB-1:0] dvd_ff, dvd_in;
   logic [31:0]   rem_ff, rem_in;
   logic [32:0]   shifted;
   logic [32:0]   diff;

   // One quotient bit per cycle, restoring; only the remainder is kept.
   always_comb begin
      shifted = {rem_ff, dvd_ff[AB-1]};
      diff    = shifted - {1'b0, divisor};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(AB);
         dvd_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[AB-2:0], 1'b0};
         rem_in = (shifted >= {1'b0, divisor}) ? diff[31:0] : shifted[31:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/typed_range_map_allocator.sv @@
// A free walks the map entry by entry; an alloc walks past entries of another kind and
// entries of its kind that do not fit, runs the alignment divider for each aligned try,
// and ends with a free when a leading fragment is cut off.
// Throughput: one transfer at a time; the next request is taken once the result is staged.
// Walk speed is set by the single entry memory read port, whose read data is registered.
// Reset is synchronous; afterwards the S_INIT state writes entry 0 before the first request.
module typed_range_map_allocator #(
   parameter int ENTRIES   = 64,
   parameter int ADDR_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   trma_req_if.sink   req_ch,
   trma_rsp_if.source rsp_ch
);
   import trma_pkg::*;

   localparam int AB = ADDR_BITS;
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int IW = $clog2(ENTRIES);
   localparam int EW = 2 * AB + KIND_W + LW;
   localparam logic [LW-1:0] END = LW'(ENTRIES);

   // Sequencer states.
   localparam logic [4:0] S_INIT  = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_OUT   = 5'd2;
   localparam logic [4:0] F_BEG   = 5'd3;
   localparam logic [4:0] F_RD    = 5'd4;
   localparam logic [4:0] F_EV    = 5'd5;
   localparam logic [4:0] F_CHK   = 5'd6;
   localparam logic [4:0] F_ADDC  = 5'd7;
   localparam logic [4:0] F_WPREV = 5'd8;
   localparam logic [4:0] F_WCUR  = 5'd9;
   localparam logic [4:0] F_RRD   = 5'd10;
   localparam logic [4:0] F_REV   = 5'd11;
   localparam logic [4:0] F_WNEW  = 5'd12;
   localparam logic [4:0] F_WPL   = 5'd13;
   localparam logic [4:0] F_RET   = 5'd14;
   localparam logic [4:0] A_BEG   = 5'd15;
   localparam logic [4:0] A_LOOP  = 5'd16;
   localparam logic [4:0] A_EV    = 5'd17;
   localparam logic [4:0] A_ADV   = 5'd18;
   localparam logic [4:0] A_CHK   = 5'd19;
   localparam logic [4:0] A_ALN   = 5'd20;
   localparam logic [4:0] A_DIV   = 5'd21;
   localparam logic [4:0] A_FIT   = 5'd22;
   localparam logic [4:0] A_COM   = 5'd23;
   localparam logic [4:0] A_WPRV  = 5'd24;
   localparam logic [4:0] A_WCUR0 = 5'd25;
   localparam logic [4:0] A_REF   = 5'd26;
   localparam logic [4:0] A_DONE  = 5'd27;
   localparam logic [4:0] A_FAIL  = 5'd28;

   // Who called the free walk, so that its end knows where to go on.
   localparam logic [1:0] CALL_TOP    = 2'd0;
   localparam logic [1:0] CALL_REFREE = 2'd1;
   localparam logic [1:0] CALL_INS1   = 2'd2;
   localparam logic [1:0] CALL_INS2   = 2'd3;

   function automatic logic [LW-1:0] clipl(input logic [LW-1:0] x);
      return (x >= END) ? END : x;
   endfunction

   // Control registers.
   logic [4:0]          state_ff, state_in;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       recycle_ff, recycle_in;
   logic [LW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   logic [OP_W-1:0]     op_ff, op_in;
   logic [AB-1:0]       st_ff, st_in;
   logic [AB-1:0]       ln_ff, ln_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [KIND_W-1:0]   a_kind_ff, a_kind_in;
   logic [ALIGN_W-1:0]  a_align_ff, a_align_in;
   logic [AB-1:0]       f_addr_ff, f_addr_in;
   logic [AB-1:0]       f_size_ff, f_size_in;
   logic [KIND_W-1:0]   f_kind_ff, f_kind_in;
   logic [AB-1:0]       f_end_ff, f_end_in;
   logic [1:0]          caller_ff, caller_in;
   logic [STATUS_W-1:0] fs_ff, fs_in;
   logic [STATUS_W-1:0] ins_st_ff, ins_st_in;
   logic [LW-1:0]       prev_ff, prev_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       steps_ff, steps_in;
   logic [AB-1:0]       prev_start_ff, prev_start_in;
   logic [AB-1:0]       prev_len_ff, prev_len_in;
   logic [KIND_W-1:0]   prev_kind_ff, prev_kind_in;
   logic [LW-1:0]       prev_link_ff, prev_link_in;
   logic [AB-1:0]       prev_end_ff, prev_end_in;
   logic [AB-1:0]       cur_start_ff, cur_start_in;
   logic [AB-1:0]       cur_len_ff, cur_len_in;
   logic [KIND_W-1:0]   cur_kind_ff, cur_kind_in;
   logic [LW-1:0]       cur_link_ff, cur_link_in;
   logic [AB-1:0]       wlen_ff, wlen_in;
   logic [LW-1:0]       wlink_ff, wlink_in;
   logic                merge2_ff, merge2_in;
   logic [LW-1:0]       fresh_ff, fresh_in;
   logic [AB-1:0]       diff_ff, diff_in;
   logic [AB-1:0]       t_ff, t_in;
   logic                gt_ff, gt_in;
   logic [AB-1:0]       end_ff, end_in;
   logic [AB-1:0]       a_ff, a_in;
   logic [AB-1:0]       ns_ff, ns_in;
   logic [AB-1:0]       num_ff, num_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AB-1:0]       res_grant_ff, res_grant_in;
   logic [STATUS_W-1:0] o_status_ff, o_status_in;
   logic [AB-1:0]       o_grant_ff, o_grant_in;

   // Entry memory access.
   logic                mem_we, mem_re;
   logic [IW-1:0]       mem_widx, mem_ridx;
   logic [EW-1:0]       mem_wdata, mem_rdata;
   logic [AB-1:0]       w_start, w_len;
   logic [KIND_W-1:0]   w_kind;
   logic [LW-1:0]       w_link;
   logic [AB-1:0]       rd_start, rd_len;
   logic [KIND_W-1:0]   rd_kind;
   logic [LW-1:0]       rd_link;

   // Alignment remainder unit.
   logic                div_start, div_done;
   logic [31:0]         div_rem;

   // Scratch values of the sequencer.
   logic [LW-1:0]       nxt;
   logic [AB-1:0]       nl;
   logic                pv, cv;

   assign mem_wdata = {w_start, w_len, w_kind, w_link};
   assign rd_start  = mem_rdata[EW-1 -: AB];
   assign rd_len    = mem_rdata[EW-AB-1 -: AB];
   assign rd_kind   = mem_rdata[LW+KIND_W-1 -: KIND_W];
   assign rd_link   = mem_rdata[LW-1:0];

   trma_entry_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_idx  (mem_widx),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_idx  (mem_ridx),
      .rd_data (mem_rdata)
   );

   trma_align_div #(
      .AB (AB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_in),
      .divisor   (a_align_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = o_status_ff;
   assign rsp_ch.granted_start = FIELD_W'(o_grant_ff);

   // The sequencer. Every map access goes through the one entry memory: a read is
   // issued in one state and its data is used in the next, and no state both reads
   // and writes, so no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      recycle_in    = recycle_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      st_in         = st_ff;
      ln_in         = ln_ff;
      kind_in       = kind_ff;
      a_kind_in     = a_kind_ff;
      a_align_in    = a_align_ff;
      f_addr_in     = f_addr_ff;
      f_size_in     = f_size_ff;
      f_kind_in     = f_kind_ff;
      f_end_in      = f_end_ff;
      caller_in     = caller_ff;
      fs_in         = fs_ff;
      ins_st_in     = ins_st_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      prev_kind_in  = prev_kind_ff;
      prev_link_in  = prev_link_ff;
      prev_end_in   = prev_end_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      cur_kind_in   = cur_kind_ff;
      cur_link_in   = cur_link_ff;
      wlen_in       = wlen_ff;
      wlink_in      = wlink_ff;
      merge2_in     = merge2_ff;
      fresh_in      = fresh_ff;
      diff_in       = diff_ff;
      t_in          = t_ff;
      gt_in         = gt_ff;
      end_in        = end_ff;
      a_in          = a_ff;
      ns_in         = ns_ff;
      num_in        = num_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      o_status_in   = o_status_ff;
      o_grant_in    = o_grant_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_widx      = '0;
      mem_ridx      = '0;
      w_start       = '0;
      w_len         = '0;
      w_kind        = KIND_NONE;
      w_link        = END;
      div_start     = 1'b0;
      nxt           = clipl(rd_link);
      nl            = end_ff - ns_ff;
      pv            = (prev_ff != END);
      cv            = (cur_ff != END);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            // Entry 0 covers all but the top address as an untyped range.
            mem_we   = 1'b1;
            mem_widx = '0;
            w_start  = '0;
            w_len    = '1;
            w_kind   = KIND_NONE;
            w_link   = END;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_ch.operation;
               st_in      = req_ch.range_start[AB-1:0];
               ln_in      = req_ch.range_length[AB-1:0];
               kind_in    = req_ch.range_kind;
               f_addr_in  = req_ch.range_start[AB-1:0];
               f_size_in  = req_ch.range_length[AB-1:0];
               f_kind_in  = req_ch.range_kind;
               caller_in  = CALL_TOP;
               a_kind_in  = req_ch.range_kind;
               a_align_in = req_ch.alignment;
               unique case (req_ch.operation)
                  OP_FREE: begin
                     state_in = F_BEG;
                  end
                  OP_ALLOC: begin
                     state_in = A_BEG;
                  end
                  OP_INSERT: begin
                     // The lookup is an untyped, unaligned alloc at the same place.
                     a_kind_in  = KIND_NONE;
                     a_align_in = '0;
                     if (req_ch.range_kind != KIND_NONE) begin
                        state_in = A_BEG;
                     end else begin
                        res_status_in = ST_OK;
                        res_grant_in  = '0;
                        state_in      = S_OUT;
                     end
                  end
                  OP_NOP: begin
                     res_status_in = ST_OK;
                     res_grant_in  = '0;
                     state_in      = S_OUT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               o_status_in  = res_status_ff;
               o_grant_in   = res_grant_ff;
               state_in     = S_IDLE;
            end
         end

         // Free walk: find the last entry that starts at or below the address.
         F_BEG: begin
            if (f_size_ff == '0) begin
               fs_in    = ST_OK;
               state_in = F_RET;
            end else begin
               f_end_in  = f_addr_ff + f_size_ff;
               prev_in   = END;
               cur_in    = clipl(head_ff);
               steps_in  = '0;
               merge2_in = 1'b0;
               state_in  = (clipl(head_ff) == END) ? F_CHK : F_RD;
            end
         end
         F_RD: begin
            mem_re   = 1'b1;
            mem_ridx = cur_ff[IW-1:0];
            state_in = F_EV;
         end
         F_EV: begin
            cur_start_in = rd_start;
            cur_len_in   = rd_len;
            cur_kind_in  = rd_kind;
            cur_link_in  = rd_link;
            if ((rd_start <= f_addr_ff) && (steps_ff < END)) begin
               prev_in       = cur_ff;
               prev_start_in = rd_start;
               prev_len_in   = rd_len;
               prev_kind_in  = rd_kind;
               prev_link_in  = rd_link;
               prev_end_in   = rd_start + rd_len;
               cur_in        = nxt;
               steps_in      = steps_ff + LW'(1);
               state_in      = (nxt == END) ? F_CHK : F_RD;
            end else begin
               state_in = F_CHK;
            end
         end
         F_CHK: begin
            priority if ((pv && (prev_end_ff > f_addr_ff)) ||
                         (cv && (f_end_ff > cur_start_ff))) begin
               fs_in    = ST_OVERLAP;
               state_in = F_RET;
            end else if (pv && (prev_kind_ff == f_kind_ff) && (prev_end_ff == f_addr_ff)) begin
               // Grows the entry below; it may also swallow the entry above.
               wlen_in  = prev_len_ff + f_size_ff;
               wlink_in = prev_link_ff;
               if (cv && (cur_kind_ff == f_kind_ff) && (f_end_ff == cur_start_ff)) begin
                  state_in = F_ADDC;
               end else begin
                  state_in = F_WPREV;
               end
            end else if (cv && (cur_kind_ff == f_kind_ff) && (f_end_ff == cur_start_ff)) begin
               mem_we   = 1'b1;
               mem_widx = cur_ff[IW-1:0];
               w_start  = cur_start_ff - f_size_ff;
               w_len    = cur_len_ff + f_size_ff;
               w_kind   = cur_kind_ff;
               w_link   = cur_link_ff;
               fs_in    = ST_OK;
               state_in = F_RET;
            end else if (clipl(recycle_ff) != END) begin
               fresh_in = recycle_ff;
               state_in = F_RRD;
            end else if (count_ff >= END) begin
               fs_in    = ST_FULL;
               state_in = F_RET;
            end else begin
               fresh_in = count_ff;
               count_in = count_ff + LW'(1);
               state_in = F_WNEW;
            end
         end
         F_ADDC: begin
            wlen_in   = wlen_ff + cur_len_ff;
            wlink_in  = clipl(cur_link_ff);
            merge2_in = 1'b1;
            state_in  = F_WPREV;
         end
         F_WPREV: begin
            mem_we   = 1'b1;
            mem_widx = prev_ff[IW-1:0];
            w_start  = prev_start_ff;
            w_len    = wlen_ff;
            w_kind   = prev_kind_ff;
            w_link   = wlink_ff;
            if (merge2_ff) begin
               state_in = F_WCUR;
            end else begin
               fs_in    = ST_OK;
               state_in = F_RET;
            end
         end
         F_WCUR: begin
            // The swallowed entry goes on the recycle list.
            mem_we     = 1'b1;
            mem_widx   = cur_ff[IW-1:0];
            w_start    = cur_start_ff;
            w_len      = cur_len_ff;
            w_kind     = cur_kind_ff;
            w_link     = clipl(recycle_ff);
            recycle_in = cur_ff;
            fs_in      = ST_OK;
            state_in   = F_RET;
         end
         F_RRD: begin
            mem_re   = 1'b1;
            mem_ridx = fresh_ff[IW-1:0];
            state_in = F_REV;
         end
         F_REV: begin
            recycle_in = nxt;
            state_in   = F_WNEW;
         end
         F_WNEW: begin
            mem_we   = 1'b1;
            mem_widx = fresh_ff[IW-1:0];
            w_start  = f_addr_ff;
            w_len    = f_size_ff;
            w_kind   = f_kind_ff;
            w_link   = cur_ff;
            if (pv) begin
               state_in = F_WPL;
            end else begin
               head_in  = fresh_ff;
               fs_in    = ST_OK;
               state_in = F_RET;
            end
         end
         F_WPL: begin
            mem_we   = 1'b1;
            mem_widx = prev_ff[IW-1:0];
            w_start  = prev_start_ff;
            w_len    = prev_len_ff;
            w_kind   = prev_kind_ff;
            w_link   = fresh_ff;
            fs_in    = ST_OK;
            state_in = F_RET;
         end
         F_RET: begin
            unique case (caller_ff)
               CALL_TOP: begin
                  res_status_in = fs_ff;
                  res_grant_in  = '0;
                  state_in      = S_OUT;
               end
               CALL_REFREE: begin
                  state_in = A_DONE;
               end
               CALL_INS1: begin
                  if (fs_ff == ST_OK) begin
                     res_status_in = ST_OK;
                     res_grant_in  = '0;
                     state_in      = S_OUT;
                  end else begin
                     // Retyping failed, so the range goes back untyped.
                     ins_st_in = fs_ff;
                     f_addr_in = st_ff;
                     f_size_in = ln_ff;
                     f_kind_in = KIND_NONE;
                     caller_in = CALL_INS2;
                     state_in  = F_BEG;
                  end
               end
               CALL_INS2: begin
                  res_status_in = ins_st_ff;
                  res_grant_in  = '0;
                  state_in      = S_OUT;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end

         // Alloc walk: first entry of the kind that fits.
         A_BEG: begin
            prev_in  = END;
            cur_in   = clipl(head_ff);
            steps_in = '0;
            state_in = A_LOOP;
         end
         A_LOOP: begin
            if ((cur_ff == END) || (steps_ff >= END)) begin
               state_in = A_FAIL;
            end else begin
               mem_re   = 1'b1;
               mem_ridx = cur_ff[IW-1:0];
               state_in = A_EV;
            end
         end
         A_EV: begin
            cur_start_in = rd_start;
            cur_len_in   = rd_len;
            cur_kind_in  = rd_kind;
            cur_link_in  = rd_link;
            diff_in      = st_ff - rd_start;
            t_in         = rd_len - ln_ff;
            gt_in        = (rd_start > st_ff);
            end_in       = rd_start + rd_len;
            state_in     = (rd_kind != a_kind_ff) ? A_ADV : A_CHK;
         end
         A_ADV: begin
            prev_in       = cur_ff;
            prev_start_in = cur_start_ff;
            prev_len_in   = cur_len_ff;
            prev_kind_in  = cur_kind_ff;
            prev_link_in  = cur_link_ff;
            cur_in        = clipl(cur_link_ff);
            steps_in      = steps_ff + LW'(1);
            state_in      = A_LOOP;
         end
         A_CHK: begin
            a_in     = cur_start_ff;
            state_in = (a_align_ff != '0) ? A_ALN : A_FIT;
            if (st_ff != '0) begin
               // Fixed address: the entry must contain it with room for the length.
               a_in = st_ff;
               priority if (gt_ff) begin
                  state_in = A_FAIL;
               end else if (cur_len_ff < diff_ff) begin
                  state_in = A_ADV;
               end else if (diff_ff > t_ff) begin
                  state_in = A_FAIL;
               end else begin
                  a_in = st_ff;
               end
            end
         end
         A_ALN: begin
            // Round up: (a + align - 1) minus its remainder by align.
            num_in    = a_ff + AB'(a_align_ff) - AB'(1);
            div_start = 1'b1;
            state_in  = A_DIV;
         end
         A_DIV: begin
            if (div_done) begin
               a_in     = num_ff - AB'(div_rem);
               state_in = A_FIT;
            end
         end
         A_FIT: begin
            if ((end_ff - a_ff) < ln_ff) begin
               state_in = A_ADV;
            end else begin
               ns_in    = a_ff + ln_ff;
               state_in = A_COM;
            end
         end
         A_COM: begin
            if (nl == '0) begin
               // The entry is used up: unlink it and recycle it.
               if (pv) begin
                  state_in = A_WPRV;
               end else begin
                  head_in  = clipl(cur_link_ff);
                  state_in = A_WCUR0;
               end
            end else begin
               mem_we   = 1'b1;
               mem_widx = cur_ff[IW-1:0];
               w_start  = ns_ff;
               w_len    = nl;
               w_kind   = cur_kind_ff;
               w_link   = cur_link_ff;
               state_in = A_REF;
            end
         end
         A_WPRV: begin
            mem_we   = 1'b1;
            mem_widx = prev_ff[IW-1:0];
            w_start  = prev_start_ff;
            w_len    = prev_len_ff;
            w_kind   = prev_kind_ff;
            w_link   = clipl(cur_link_ff);
            state_in = A_WCUR0;
         end
         A_WCUR0: begin
            mem_we     = 1'b1;
            mem_widx   = cur_ff[IW-1:0];
            w_start    = ns_ff;
            w_len      = '0;
            w_kind     = cur_kind_ff;
            w_link     = clipl(recycle_ff);
            recycle_in = cur_ff;
            state_in   = A_REF;
         end
         A_REF: begin
            if (cur_start_ff != a_ff) begin
               // The leading fragment cut off by the grant is freed again.
               f_addr_in = cur_start_ff;
               f_size_in = a_ff - cur_start_ff;
               f_kind_in = a_kind_ff;
               caller_in = CALL_REFREE;
               state_in  = F_BEG;
            end else begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            if (op_ff == OP_ALLOC) begin
               res_status_in = ST_OK;
               res_grant_in  = a_ff;
               state_in      = S_OUT;
            end else if (a_ff == '0) begin
               // A lookup granted at address zero counts as a miss; the grant stays.
               res_status_in = ST_NOFIT;
               res_grant_in  = '0;
               state_in      = S_OUT;
            end else begin
               f_addr_in = st_ff;
               f_size_in = ln_ff;
               f_kind_in = kind_ff;
               caller_in = CALL_INS1;
               state_in  = F_BEG;
            end
         end
         A_FAIL: begin
            res_status_in = ST_NOFIT;
            res_grant_in  = '0;
            state_in      = S_OUT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         head_ff      <= '0;
         recycle_ff   <= END;
         count_ff     <= LW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         recycle_ff   <= recycle_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      st_ff         <= st_in;
      ln_ff         <= ln_in;
      kind_ff       <= kind_in;
      a_kind_ff     <= a_kind_in;
      a_align_ff    <= a_align_in;
      f_addr_ff     <= f_addr_in;
      f_size_ff     <= f_size_in;
      f_kind_ff     <= f_kind_in;
      f_end_ff      <= f_end_in;
      caller_ff     <= caller_in;
      fs_ff         <= fs_in;
      ins_st_ff     <= ins_st_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      prev_kind_ff  <= prev_kind_in;
      prev_link_ff  <= prev_link_in;
      prev_end_ff   <= prev_end_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      cur_kind_ff   <= cur_kind_in;
      cur_link_ff   <= cur_link_in;
      wlen_ff       <= wlen_in;
      wlink_ff      <= wlink_in;
      merge2_ff     <= merge2_in;
      fresh_ff      <= fresh_in;
      diff_ff       <= diff_in;
      t_ff          <= t_in;
      gt_ff         <= gt_in;
      end_ff        <= end_in;
      a_ff          <= a_in;
      ns_ff         <= ns_in;
      num_ff        <= num_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      o_status_ff   <= o_status_in;
      o_grant_ff    <= o_grant_in;
   end

`ifndef SYNTHESIS
   // A read and a write of the same entry never share a cycle.
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_widx != mem_ridx))
      else $error("entry memory read and written at the same index");

   // Fresh entries are handed out only up to the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= END)
      else $error("fresh entry count beyond the table");

   // One request in flight: a transfer is never followed directly by another.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while another is in flight");
`endif

endmodule

@@ dv/typed_range_map_allocator_checker.sv @@
module typed_range_map_allocator_checker (
   input logic      clock,
   input logic      reset,
   trma_req_if      req_ch,
   trma_rsp_if      rsp_ch,
   output int       fail_count,
   output int       pending_count
);
   import trma_pkg::*;

   localparam int NE = 64;
   localparam logic [6:0] ENDM = 7'd64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  granted;
   } outcome_type;

   logic [63:0] m_start [NE];
   logic [63:0] m_len   [NE];
   logic [2:0]  m_kind  [NE];
   logic [6:0]  m_link  [NE];
   logic [6:0]  head, recyc, fresh_n;
   outcome_type awaited[$];

   function automatic logic [6:0] nxt(logic [6:0] i);
      if (i >= ENDM) return ENDM;
      return (m_link[i] >= ENDM) ? ENDM : m_link[i];
   endfunction

   function automatic logic [6:0] lim(logic [6:0] i);
      return (i >= ENDM) ? ENDM : i;
   endfunction

   function automatic logic [1:0] map_free(logic [63:0] addr, logic [63:0] size,
                                           logic [2:0] kind);
      logic [6:0] prv, cur, fr;
      int steps;
      prv = ENDM; cur = lim(head); steps = 0;
      if (size == 0) return ST_OK;
      while (cur != ENDM && m_start[cur] <= addr && steps < NE) begin
         prv = cur; cur = nxt(cur); steps++;
      end
      if ((prv != ENDM && (m_start[prv] + m_len[prv]) > addr) ||
          (cur != ENDM && (addr + size) > m_start[cur]))
         return ST_OVERLAP;
      if (prv != ENDM && m_kind[prv] == kind && (m_start[prv] + m_len[prv]) == addr) begin
         m_len[prv] = m_len[prv] + size;
         if (cur != ENDM && m_kind[cur] == kind && (addr + size) == m_start[cur]) begin
            m_len[prv] = m_len[prv] + m_len[cur];
            m_link[prv] = nxt(cur);
            m_link[cur] = lim(recyc);
            recyc = cur;
         end
         return ST_OK;
      end
      if (cur != ENDM && m_kind[cur] == kind && (addr + size) == m_start[cur]) begin
         m_start[cur] = m_start[cur] - size;
         m_len[cur] = m_len[cur] + size;
         return ST_OK;
      end
      if (lim(recyc) != ENDM) begin
         fr = recyc; recyc = nxt(fr);
      end else begin
         if (fresh_n >= ENDM) return ST_FULL;
         fr = fresh_n; fresh_n = fresh_n + 1;
      end
      m_start[fr] = addr; m_len[fr] = size; m_kind[fr] = kind; m_link[fr] = cur;
      if (prv == ENDM) head = fr;
      else m_link[prv] = fr;
      return ST_OK;
   endfunction

   function automatic logic [1:0] map_alloc(logic [63:0] addr, logic [63:0] size,
                                            logic [2:0] kind, logic [63:0] align,
                                            output logic [63:0] grant);
      logic [6:0] prv, cur;
      int steps;
      logic [63:0] a, o;
      logic [1:0] dummy;
      grant = '0; prv = ENDM; cur = lim(head); steps = 0;
      while (cur != ENDM && steps < NE) begin
         if (m_kind[cur] == kind) begin
            a = m_start[cur];
            if (addr != 0) begin
               if (a > addr) return ST_NOFIT;
               if (m_len[cur] < (addr - a)) begin
                  prv = cur; cur = nxt(cur); steps++;
                  continue;
               end
               if ((addr - a) > (m_len[cur] - size)) return ST_NOFIT;
               a = addr;
            end
            if (align != 0) a = ((a + align - 1) / align) * align;
            if ((m_start[cur] + m_len[cur] - a) >= size) begin
               o = m_start[cur];
               m_start[cur] = a + size;
               m_len[cur] = m_len[cur] - (a - o + size);
               if (m_len[cur] == 0) begin
                  if (prv == ENDM) head = nxt(cur);
                  else m_link[prv] = nxt(cur);
                  m_link[cur] = lim(recyc);
                  recyc = cur;
               end
               if (o != a) dummy = map_free(o, a - o, kind);
               grant = a;
               return ST_OK;
            end
         end
         prv = cur; cur = nxt(cur); steps++;
      end
      return ST_NOFIT;
   endfunction

   function automatic outcome_type predict_outcome(logic [1:0] op, logic [63:0] st,
                                                   logic [63:0] ln, logic [2:0] kd,
                                                   logic [31:0] al);
      outcome_type r;
      logic [63:0] got;
      logic [1:0] dummy;
      r = '0;
      if (op == OP_FREE) r.status = map_free(st, ln, kd);
      else if (op == OP_ALLOC) r.status = map_alloc(st, ln, kd, {32'd0, al}, r.granted);
      else if (op == OP_INSERT && kd != KIND_NONE) begin
         if (map_alloc(st, ln, KIND_NONE, 64'd0, got) != ST_OK || got == 0)
            r.status = ST_NOFIT;
         else begin
            r.status = map_free(st, ln, kd);
            if (r.status != ST_OK) dummy = map_free(st, ln, KIND_NONE);
         end
      end
      return r;
   endfunction

   assign pending_count = awaited.size();

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         for (int i = 0; i < NE; i++) begin
            m_start[i] = '0; m_len[i] = '0; m_kind[i] = '0; m_link[i] = ENDM;
         end
         m_len[0] = '1;
         head = '0; recyc = ENDM; fresh_n = 7'd1;
         fail_count <= 0;
         awaited.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            awaited.push_back(predict_outcome(req_ch.operation, req_ch.range_start,
                                              req_ch.range_length, req_ch.range_kind,
                                              req_ch.alignment));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result status %0d start %h", $time,
                        rsp_ch.status, rsp_ch.granted_start);
               fail_count <= fail_count + 1;
            end else begin
               e = awaited.pop_front();
               if (e.status !== rsp_ch.status || e.granted !== rsp_ch.granted_start) begin
                  $display("%0t: mismatch expected status %0d start %h, actual status %0d start %h",
                           $time, e.status, e.granted, rsp_ch.status, rsp_ch.granted_start);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ dv/typed_range_map_allocator_tb.sv @@
module typed_range_map_allocator_tb;
   import trma_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;

   // Generous bound: an aligned alloc runs the divider for every entry that it tries,
   // and there are about 1150 requests plus idle gaps.
   localparam int CYCLE_LIMIT = 30000000;

   trma_req_if req_ch ();
   trma_rsp_if rsp_ch ();

   typed_range_map_allocator uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   typed_range_map_allocator_checker chk (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // The cycle counter guards against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("typed_range_map_allocator test failed");
         $finish;
      end
   end

   // The receiver stalls for a random number of cycles before each transfer,
   // and before some transfers it does not stall at all.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         repeat (gap) @(posedge clock);
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_ch.ready <= 1'b0;
      end
   end

   // Sends one request and holds it until the transfer happens. The task
   // picks the idle gap itself beforehand, so valid is never dropped and raised
   // again within one step.
   task automatic send_req(logic [1:0] op, logic [63:0] st, logic [63:0] ln,
                           logic [2:0] kd, logic [31:0] al);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.operation    <= op;
      req_ch.range_start  <= st;
      req_ch.range_length <= ln;
      req_ch.range_kind   <= kd;
      req_ch.alignment    <= al;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Addresses cluster in a small window so that ranges touch, overlap and merge.
   function automatic logic [63:0] near_addr();
      case ($urandom_range(0, 9))
         0:       return rand64();
         1:       return 64'hFFFF_FFFF_FFFF_F000 + $urandom_range(0, 4095);
         2:       return 64'd0;
         default: return 64'(($urandom_range(0, 255)) * 16 + $urandom_range(0, 3) * 4);
      endcase
   endfunction

   function automatic logic [63:0] near_len();
      case ($urandom_range(0, 9))
         0:       return rand64();
         1:       return 64'd0;
         2:       return 64'hFFFF_FFFF_FFFF_FFFF;
         default: return 64'($urandom_range(1, 96));
      endcase
   endfunction

   function automatic logic [31:0] pick_align();
      case ($urandom_range(0, 5))
         0, 1:    return 32'd0;
         2:       return $urandom();
         3:       return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_NOP;
      req_ch.range_start  <= '0;
      req_ch.range_length <= '0;
      req_ch.range_kind   <= KIND_NONE;
      req_ch.alignment    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, every operation, and the special cases.
      send_req(OP_FREE, 64'h100, 64'd0, 3'd1, 32'd0);            // zero-length free
      send_req(OP_FREE, 64'h100, 64'h10, 3'd0, 32'd0);           // overlap with initial range
      send_req(OP_INSERT, 64'h1000, 64'h100, 3'd1, 32'd0);       // retype to memory
      send_req(OP_INSERT, 64'h1100, 64'h100, 3'd1, 32'd0);       // merge at the left side
      send_req(OP_INSERT, 64'h0F00, 64'h100, 3'd1, 32'd0);       // merge at the right side
      send_req(OP_INSERT, 64'h0, 64'h10, 3'd2, 32'd0);           // lookup grants address 0
      send_req(OP_INSERT, 64'h2000, 64'h10, 3'd0, 32'd0);        // insert of kind none
      send_req(OP_ALLOC, 64'd0, 64'h20, 3'd1, 32'd0);            // any address, head fragment
      send_req(OP_ALLOC, 64'd0, 64'h10, 3'd1, 32'd64);           // aligned, re-frees fragment
      send_req(OP_ALLOC, 64'h1180, 64'h80, 3'd1, 32'd0);         // fixed address, tail
      send_req(OP_ALLOC, 64'h5000, 64'h10, 3'd1, 32'd0);         // no fit
      send_req(OP_ALLOC, 64'd0, 64'h10, 3'd7, 32'hFFFF_FFFF);    // kind never present
      send_req(OP_NOP, '1, '1, 3'd7, '1);                        // ignored
      send_req(OP_ALLOC, 64'd0, 64'h10, 3'd0, 32'd0);            // kind-0 grant from the lowest untyped range
      send_req(OP_ALLOC, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 32'd0);
      send_req(OP_FREE, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 3'd5, 32'd0); // wrapping end
      send_req(OP_FREE, 64'h0, 64'h10, 3'd0, 32'd0);
      send_req(OP_FREE, 64'h1000, 64'h1000, 3'd1, 32'd0);
      send_req(OP_ALLOC, 64'h1, 64'h1, 3'd0, 32'h8000_0000);
      // Fill the table with scattered single bytes until it runs full.
      for (int i = 0; i < 70; i++)
         send_req(OP_INSERT, 64'h10_0000 + i * 64'h40, 64'd1, 3'(1 + i % 7), 32'd0);
      // Hold off until every result has come, then drain the table back.
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 70; i++)
         send_req(OP_ALLOC, 64'h10_0000 + i * 64'h40, 64'd1, 3'(1 + i % 7), 32'd0);

      // Random part: mostly coherent free/alloc/insert on a small window.
      for (int n = 0; n < 1000; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: op = OP_FREE;
            3, 4, 5: op = OP_ALLOC;
            6, 7, 8: op = OP_INSERT;
            default: op = OP_NOP;
         endcase
         send_req(op, near_addr(), near_len(), 3'($urandom_range(0, 7)), pick_align());
      end
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("typed_range_map_allocator test passed");
      end else begin
         $display("typed_range_map_allocator test failed");
      end
      $finish;
   end

endmodule
